@@ src/assert_macros.svh @@
// Assertion macros shared by the mailbox/timer bridge RTL.
// No dependencies; include after the timescale line.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/schmt_pkg.sv @@
// Types and constants for the host/card mailbox bridge with timers.
// No dependencies.
`timescale 1ns / 1ps
package schmt_pkg;

  typedef enum logic [2:0] {
    FN_HOST_WR = 3'd0,
    FN_HOST_RD = 3'd1,
    FN_CARD_WR = 3'd2,
    FN_CARD_RD = 3'd3,
    FN_TICK    = 3'd4
  } func_t;

  localparam logic [3:0] HOST_DATA   = 4'd0;
  localparam logic [3:0] HOST_PEEK   = 4'd1;
  localparam logic [3:0] HOST_STATUS = 4'd2;
  localparam logic [3:0] BIT_SET     = 4'd3;
  localparam logic [3:0] CARD_DATA   = 4'd0;
  localparam logic [3:0] CARD_TAKE   = 4'd1;
  localparam logic [3:0] CARD_STATUS = 4'd2;

  localparam logic [1:0] HOST_GRP_TIMER = 2'b01;
  localparam logic [1:0] HOST_GRP_CTRL  = 2'b10;
  localparam logic [1:0] HOST_GRP_STAT  = 2'b11;
  localparam logic [1:0] TIMER_MODE_SEL = 2'd3;

  localparam logic [2:0] SEL_HOST_RX  = 3'd4;
  localparam logic [2:0] SEL_HOST_TX  = 3'd2;
  localparam logic [2:0] SEL_CARD_TX  = 3'd6;
  localparam logic [2:0] SEL_CARD_RX  = 3'd2;
  localparam logic [2:0] SEL_EXTRA    = 3'd5;

  localparam int unsigned EN_CARD_RX = 0;
  localparam int unsigned EN_HOST_TX = 1;
  localparam int unsigned EN_HOST_RX = 2;
  localparam int unsigned EN_CARD_TX = 3;

  localparam logic [7:0]  RD_UNMAPPED  = 8'hFF;
  localparam logic [7:0]  TSTAT_FIXED  = 8'h7C;
  localparam logic [16:0] RELOAD_ZERO  = 17'h10000;
  localparam logic [33:0] PROD_RESET   = 34'h1_0000_0000;

  typedef logic [15:0] latch_t;
  typedef logic [16:0] reload_t;

  function automatic reload_t reload_of(input latch_t l);
    reload_of = (l == '0) ? RELOAD_ZERO : {1'b0, l};
  endfunction

endpackage

@@ src/schmt_if.sv @@
// Valid/ready channel interfaces for bus items and result items.
// Depends on nothing.
`timescale 1ns / 1ps
interface schmt_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [3:0] addr;
  logic [7:0] wdata;
  modport source (output valid, func, addr, wdata, input ready);
  modport sink   (input valid, func, addr, wdata, output ready);
endinterface

interface schmt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic       host_irq;
  logic       card_irq;
  modport source (output valid, rdata, host_irq, card_irq, input ready);
  modport sink   (input valid, rdata, host_irq, card_irq, output ready);
endinterface

@@ src/sound_card_host_mailbox_timers.sv @@
// Host/card mailbox bridge with two timers; one result item per bus item.
// Result is registered, valid in the cycle after accept; throughput 1 item per
// cycle; the output register stalls intake only while a result waits on out_ch.ready.
// Synchronous active-low reset clears mailboxes, enables, timers and latches.
// Depends on schmt_pkg, schmt_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sound_card_host_mailbox_timers #(
  parameter int A_PRESCALE = 4
) (
  input logic clk,
  input logic rst_n,
  schmt_in_if.sink    in_ch,
  schmt_out_if.source out_ch
);
  import schmt_pkg::*;

  localparam int PS_W = $clog2(A_PRESCALE + 1);
  localparam logic [PS_W-1:0] PS_LAST = PS_W'(A_PRESCALE);

  logic [7:0]  to_card_byte_r, to_card_byte_nxt;
  logic        to_card_full_r, to_card_full_nxt;
  logic [7:0]  to_host_byte_r, to_host_byte_nxt;
  logic        to_host_full_r, to_host_full_nxt;
  logic [3:0]  irq_en_r, irq_en_nxt;
  logic        extra_r, extra_nxt;
  logic [7:0]  tctl_r, tctl_nxt;
  logic [1:0]  tflags_r, tflags_nxt;
  logic [5:0]  mode_r [3];
  logic [5:0]  mode_nxt [3];
  latch_t      latch_r [3];
  latch_t      latch_nxt [3];
  logic [2:0]  hbn_r, hbn_nxt;
  logic [17:0] count_a_r, count_a_nxt;
  logic [33:0] count_b_r, count_b_nxt;
  logic [33:0] prod_r;
  logic [PS_W-1:0] ps_r, ps_nxt, ps_inc;
  reload_t     rel_a;

  logic        out_valid_r;
  logic [7:0]  rdata_r, rdata_nxt;
  logic        host_irq_r, card_irq_r;
  logic        acc;
  logic [3:0]  a;
  logic [7:0]  v;
  logic [1:0]  tsel;
  logic [1:0]  mch;
  logic        host_tx_irq, host_rx_irq, card_rx_irq, card_tx_irq;
  logic        host_pend;

  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign a = in_ch.addr;
  assign v = in_ch.wdata;
  assign tsel = a[1:0];
  assign mch = v[7:6];
  assign rel_a = reload_of(latch_r[0]);
  assign ps_inc = ps_r + PS_W'(1);

  assign host_tx_irq = !to_card_full_r && irq_en_r[EN_HOST_TX];
  assign host_rx_irq = to_host_full_r && irq_en_r[EN_HOST_RX];
  assign card_rx_irq = to_card_full_r && irq_en_r[EN_CARD_RX];
  assign card_tx_irq = !to_host_full_r && irq_en_r[EN_CARD_TX];
  assign host_pend = (tflags_r != '0) || host_tx_irq || host_rx_irq;

  always_comb begin
    to_card_byte_nxt = to_card_byte_r;
    to_card_full_nxt = to_card_full_r;
    to_host_byte_nxt = to_host_byte_r;
    to_host_full_nxt = to_host_full_r;
    irq_en_nxt = irq_en_r;
    extra_nxt = extra_r;
    tctl_nxt = tctl_r;
    tflags_nxt = tflags_r;
    hbn_nxt = hbn_r;
    count_a_nxt = count_a_r;
    count_b_nxt = count_b_r;
    ps_nxt = ps_r;
    rdata_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      mode_nxt[i] = mode_r[i];
      latch_nxt[i] = latch_r[i];
    end
    if (acc) begin
      case (func_t'(in_ch.func))
        FN_HOST_WR: begin
          if (a == HOST_PEEK) begin
            to_card_byte_nxt = v;
            to_card_full_nxt = 1'b1;
          end else if (a == BIT_SET) begin
            if (!v[7]) begin
              if (v[3:1] == SEL_HOST_RX) irq_en_nxt[EN_HOST_RX] = v[0];
              else if (v[3:1] == SEL_HOST_TX) irq_en_nxt[EN_HOST_TX] = v[0];
            end
          end else if (a[3:2] == HOST_GRP_TIMER) begin
            if (tsel == TIMER_MODE_SEL) begin
              for (int i = 0; i < 3; i++) begin
                if (mch == 2'(i)) begin
                  mode_nxt[i] = v[5:0];
                  hbn_nxt[i] = !v[4];
                end
              end
            end else begin
              for (int i = 0; i < 3; i++) begin
                if (tsel == 2'(i)) begin
                  if (hbn_r[i]) latch_nxt[i] = {v, latch_r[i][7:0]};
                  else latch_nxt[i] = {latch_r[i][15:8], v};
                  if (mode_r[i][5]) hbn_nxt[i] = !hbn_r[i];
                end
              end
              if (tsel == 2'd0) count_a_nxt = '0;
              else count_b_nxt = '0;
            end
          end else if (a[3:2] == HOST_GRP_CTRL) begin
            tctl_nxt = v;
            tflags_nxt = tflags_r & v[1:0];
          end
        end
        FN_HOST_RD: begin
          rdata_nxt = RD_UNMAPPED;
          if (a == HOST_DATA) begin
            rdata_nxt = to_host_byte_r;
            to_host_full_nxt = 1'b0;
          end else if (a == HOST_PEEK) begin
            rdata_nxt = to_card_byte_r;
          end else if (a == HOST_STATUS) begin
            rdata_nxt = {extra_r, 1'b0, to_host_full_r, irq_en_r[EN_HOST_RX],
                         host_rx_irq, irq_en_r[EN_HOST_TX], !to_card_full_r,
                         host_tx_irq};
          end else if (a[3:2] == HOST_GRP_STAT) begin
            rdata_nxt = {host_pend, 7'd0} | TSTAT_FIXED | {6'd0, tflags_r};
          end
        end
        FN_CARD_WR: begin
          if (a == CARD_DATA) begin
            to_host_byte_nxt = v;
            to_host_full_nxt = 1'b1;
          end else if (a == BIT_SET && !v[7]) begin
            if (v[3:1] == SEL_CARD_TX) irq_en_nxt[EN_CARD_TX] = v[0];
            else if (v[3:1] == SEL_CARD_RX) irq_en_nxt[EN_CARD_RX] = v[0];
            else if (v[3:1] == SEL_EXTRA) extra_nxt = v[0];
          end
        end
        FN_CARD_RD: begin
          rdata_nxt = RD_UNMAPPED;
          if (a == CARD_DATA) begin
            rdata_nxt = to_host_byte_r;
          end else if (a == CARD_TAKE) begin
            rdata_nxt = to_card_byte_r;
            to_card_full_nxt = 1'b0;
          end else if (a == CARD_STATUS) begin
            rdata_nxt = {!to_host_full_r, irq_en_r[EN_CARD_TX], extra_r, 1'b0,
                         card_tx_irq, irq_en_r[EN_CARD_RX], to_card_full_r,
                         card_rx_irq};
          end
        end
        FN_TICK: begin
          if (ps_inc >= PS_LAST) begin
            ps_nxt = '0;
            if (count_a_r == '0) begin
              count_a_nxt = (rel_a == 17'd1) ? 18'd1 : 18'(rel_a - 17'd1);
              tflags_nxt[0] = tflags_nxt[0] | tctl_r[2];
            end else if (count_a_r == 18'd1) begin
              count_a_nxt = 18'(rel_a);
              tflags_nxt[0] = tflags_nxt[0] | tctl_r[2];
            end else begin
              count_a_nxt = count_a_r - 18'd1;
            end
          end else begin
            ps_nxt = ps_inc;
          end
          if (count_b_r == '0) begin
            count_b_nxt = (prod_r == 34'd1) ? 34'd1 : prod_r - 34'd1;
            tflags_nxt[1] = tflags_nxt[1] | tctl_r[3];
          end else if (count_b_r == 34'd1) begin
            count_b_nxt = prod_r;
            tflags_nxt[1] = tflags_nxt[1] | tctl_r[3];
          end else begin
            count_b_nxt = count_b_r - 34'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      to_card_byte_r <= '0;
      to_card_full_r <= 1'b0;
      to_host_byte_r <= '0;
      to_host_full_r <= 1'b0;
      irq_en_r <= '0;
      extra_r <= 1'b0;
      tctl_r <= '0;
      tflags_r <= '0;
      hbn_r <= '0;
      count_a_r <= '0;
      count_b_r <= '0;
      ps_r <= '0;
      prod_r <= PROD_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        mode_r[i] <= '0;
        latch_r[i] <= '0;
      end
    end else begin
      to_card_byte_r <= to_card_byte_nxt;
      to_card_full_r <= to_card_full_nxt;
      to_host_byte_r <= to_host_byte_nxt;
      to_host_full_r <= to_host_full_nxt;
      irq_en_r <= irq_en_nxt;
      extra_r <= extra_nxt;
      tctl_r <= tctl_nxt;
      tflags_r <= tflags_nxt;
      hbn_r <= hbn_nxt;
      count_a_r <= count_a_nxt;
      count_b_r <= count_b_nxt;
      ps_r <= ps_nxt;
      prod_r <= 34'(reload_of(latch_nxt[1])) * 34'(reload_of(latch_nxt[2]));
      for (int i = 0; i < 3; i++) begin
        mode_r[i] <= mode_nxt[i];
        latch_r[i] <= latch_nxt[i];
      end
      if (acc) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rdata_r <= rdata_nxt;
      host_irq_r <= ((tflags_nxt != '0)
                     || (!to_card_full_nxt && irq_en_nxt[EN_HOST_TX])
                     || (to_host_full_nxt && irq_en_nxt[EN_HOST_RX]))
                    && tctl_nxt[7] && tctl_nxt[6];
      card_irq_r <= (to_card_full_nxt && irq_en_nxt[EN_CARD_RX])
                    || (!to_host_full_nxt && irq_en_nxt[EN_CARD_TX]);
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.rdata = rdata_r;
  assign out_ch.host_irq = host_irq_r;
  assign out_ch.card_irq = card_irq_r;

  `ASSERT_IMPLIES(a_stall_only_on_full, clk, rst_n, !in_ch.ready, out_valid_r && !out_ch.ready, "intake stalled without a waiting result")
  `ASSERT_IMPLIES(a_count_a_range, clk, rst_n, 1'b1, count_a_r <= 18'(RELOAD_ZERO), "timer A count above reload range")
  `ASSERT_IMPLIES(a_prescale_range, clk, rst_n, 1'b1, ps_r < PS_LAST, "prescaler out of range")
  `ASSERT_NEXT(a_card_take_clears, clk, rst_n, acc && in_ch.func == FN_CARD_RD && in_ch.addr == CARD_TAKE, !to_card_full_r, "card take left mailbox full")

endmodule
